@@ hdl/mawr_pkg.sv @@
package mawr_pkg;

    // field and register widths
    localparam int CH_W      = 8;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;
    localparam int SUM2_W    = 9;
    localparam int SUM4_W    = 10;

    // default maximum source size
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 1'b1;

    // one rgba pixel, red in the lowest byte
    typedef logic [3:0][CH_W-1:0] pixel_t;

    // channel sums of one reduced pixel on their way into the filter
    typedef struct packed {
        logic [3:0][SUM4_W-1:0] sum;
        logic                   quad;
        logic                   last;
    } filt_item_t;

endpackage

@@ hdl/mawr_filter.sv @@
module mawr_filter (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  mawr_pkg::filt_item_t in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output mawr_pkg::pixel_t   out_pixel,
    output logic               out_last
);
    import mawr_pkg::*;

    localparam int PROD_W = 2 * SUM4_W;
    localparam int X_W    = 16;

    // floor(x / 255) for x up to 65025, by estimate and one correction
    function automatic logic [CH_W-1:0] div255(input logic [X_W-1:0] x);
        logic [X_W:0] x_ext;
        logic [X_W:0] est_sum;
        logic [X_W:0] q_est;
        logic [X_W:0] q_times;
        logic [X_W:0] rem;
        logic [X_W:0] q_fix;
        x_ext   = {1'b0, x};
        est_sum = x_ext + (x_ext >> 8);
        q_est   = est_sum >> 8;
        q_times = (q_est << 8) - q_est;
        rem     = x_ext - q_times;
        q_fix   = (rem >= (X_W+1)'(255)) ? q_est + (X_W+1)'(1) : q_est;
        return q_fix[CH_W-1:0];
    endfunction

    logic                  va_reg;
    logic [2:0][X_W-1:0]   x_reg;
    logic [CH_W-1:0]       alpha_reg;
    logic                  last_a_reg;

    logic                  out_valid_reg;
    pixel_t                pixel_reg;
    logic                  out_last_reg;

    logic                  out_adv;
    logic                  a_adv;
    logic [2:0][X_W-1:0]   x_next;
    logic [CH_W-1:0]       alpha_next;

    // ready chain, bubbles collapse
    assign out_adv  = !out_valid_reg || out_ready;
    assign a_adv    = !va_reg || out_adv;
    assign in_ready = a_adv;

    // colour times alpha sum, scaled down to the divide by 255
    always_comb begin
        logic [PROD_W-1:0] prod;
        for (int k = 0; k < 3; k++) begin
            prod      = PROD_W'(in_item.sum[k]) * PROD_W'(in_item.sum[3]);
            x_next[k] = in_item.quad ? X_W'(prod >> 4) : X_W'(prod >> 2);
        end
        alpha_next = in_item.quad ? CH_W'(in_item.sum[3] >> 2) : CH_W'(in_item.sum[3] >> 1);
    end

    // product stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
        end else if (a_adv) begin
            va_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_adv && in_valid) begin
            x_reg      <= x_next;
            alpha_reg  <= alpha_next;
            last_a_reg <= in_item.last;
        end
    end

    // output register with the divide by 255
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_adv) begin
            out_valid_reg <= va_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_adv && va_reg) begin
            for (int k = 0; k < 3; k++) begin
                pixel_reg[k] <= div255(x_reg[k]);
            end
            pixel_reg[3] <= alpha_reg;
            out_last_reg <= last_a_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_pixel = pixel_reg;
    assign out_last  = out_last_reg;

endmodule

@@ hdl/mipmap_alpha_weighted_reduce.sv @@
// Mipmap reduction of an rgba8 image streamed in raster order.
// s_ channel: one source pixel per word. m_ channel: one pixel of the next
// mip level per word, in raster order, m_tlast on its final pixel.
// Source size is set through the write port (index 0 width, index 1 height,
// 0 acts as 1, values above the maximum act as the maximum); a write also
// restarts the frame position. Write only while the block is idle.
// Both sizes above 1: each 2x2 block gives one pixel, alpha weighted colour.
// One size equal to 1: consecutive pixel pairs give one pixel.
// Trailing odd columns, rows or pixels are taken and give nothing.
// Throughput: one pixel per clock while m_tready is high, set by the single line
// memory, which sees at most one read or one write per pixel. The result passes
// through the first stage, the product stage and the filter's output register.
// Reset: size 2x2, position at the frame start, the line memory is left as
// it is (an odd row only reads entries written by the row above it).
// When m_tready is low the output word holds, the internal stages fill up
// and s_tready then drops; nothing is lost.
module mipmap_alpha_weighted_reduce #(
    parameter int MAX_WIDTH  = mawr_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = mawr_pkg::DEF_MAX_HEIGHT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration write port
    input  logic                           cfg_wr_en,
    input  logic [mawr_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [mawr_pkg::CFG_W-1:0]     cfg_wr_data,
    // source pixels
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [31:0]                    s_tdata,  // in_red, in_green, in_blue, in_alpha
    // reduced pixels
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [31:0]                    m_tdata,  // out_red, out_green, out_blue, out_alpha
    output logic                           m_tlast   // last_pixel
);
    import mawr_pkg::*;

    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int SLOT_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int MAX_DIM    = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int DIM_BITS   = $clog2(MAX_DIM + 1);
    localparam int DIM_W      = (DIM_BITS > CFG_W) ? DIM_BITS : CFG_W;
    localparam int LINE_W     = 4 * SUM2_W;

    // sizes, held already clamped
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    pixel_t           held_reg;

    logic [DIM_W-1:0] cfg_ext;
    logic [DIM_W-1:0] width_clamp;
    logic [DIM_W-1:0] height_clamp;

    // size clamp on write
    always_comb begin
        cfg_ext      = DIM_W'(cfg_wr_data);
        width_clamp  = (cfg_ext == '0) ? DIM_W'(1) :
                       (cfg_ext > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : cfg_ext;
        height_clamp = (cfg_ext == '0) ? DIM_W'(1) :
                       (cfg_ext > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : cfg_ext;
    end

    pixel_t           cur_pixel;
    logic             accept;
    logic [DIM_W-1:0] col_ext;
    logic [DIM_W-1:0] row_ext;
    logic [DIM_W-1:0] used_w;
    logic [DIM_W-1:0] used_h;
    logic [DIM_W-1:0] pos;
    logic [DIM_W-1:0] used;
    logic             w_one;
    logic             h_one;
    logic             pair_take;
    logic             quad_take;
    logic             hold_en;
    logic             line_wr;
    logic             line_rd;
    logic             emit;
    logic             emit_last;
    logic [SLOT_W-1:0] slot;
    logic [3:0][SUM2_W-1:0] pair_sum;

    assign cur_pixel = pixel_t'(s_tdata);
    assign accept    = s_tvalid && s_tready;

    // decode of the current position
    always_comb begin
        col_ext   = DIM_W'(col_reg);
        row_ext   = DIM_W'(row_reg);
        w_one     = (width_reg == DIM_W'(1));
        h_one     = (height_reg == DIM_W'(1));
        used_w    = {width_reg[DIM_W-1:1], 1'b0};
        used_h    = {height_reg[DIM_W-1:1], 1'b0};
        pos       = h_one ? col_ext : row_ext;
        used      = h_one ? used_w : used_h;
        pair_take = (w_one ^ h_one) && (pos < used);
        quad_take = !w_one && !h_one && (col_ext < used_w) && (row_ext < used_h);
        hold_en   = (pair_take && !pos[0]) || (quad_take && !col_ext[0]);
        line_wr   = quad_take && col_ext[0] && !row_ext[0];
        line_rd   = quad_take && col_ext[0] && row_ext[0];
        emit      = (pair_take && pos[0]) || line_rd;
        emit_last = pair_take ? (pos == used - DIM_W'(1)) :
                    ((col_ext == used_w - DIM_W'(1)) && (row_ext == used_h - DIM_W'(1)));
        slot      = SLOT_W'(col_reg >> 1);
        for (int k = 0; k < 4; k++) begin
            pair_sum[k] = SUM2_W'(held_reg[k]) + SUM2_W'(cur_pixel[k]);
        end
    end

    logic [DIM_W-1:0] col_inc;
    logic [DIM_W-1:0] row_inc;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_next;
    logic             col_wrap;

    // raster position advance
    always_comb begin
        col_inc  = col_ext + DIM_W'(1);
        row_inc  = row_ext + DIM_W'(1);
        col_wrap = (col_inc >= width_reg);
        col_next = col_wrap ? '0 : col_inc[COL_W-1:0];
        row_next = row_reg;
        if (col_wrap) begin
            row_next = (row_inc >= height_reg) ? '0 : row_inc[ROW_W-1:0];
        end
    end

    // configuration and position registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= DIM_W'(2);
            height_reg <= DIM_W'(2);
            col_reg    <= '0;
            row_reg    <= '0;
        end else if (cfg_wr_en) begin
            col_reg <= '0;
            row_reg <= '0;
            case (cfg_addr)
                REG_SOURCE_WIDTH: begin
                    width_reg <= width_clamp;
                end
                REG_SOURCE_HEIGHT: begin
                    height_reg <= height_clamp;
                end
                default: begin
                end
            endcase
        end else if (accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // first pixel of a pair (left, or upper when the width is 1)
    always_ff @(posedge aclk) begin
        if (accept && hold_en) begin
            held_reg <= cur_pixel;
        end
    end

    // line memory of even row pair sums
    logic [LINE_W-1:0] line_mem [LINE_DEPTH];
    logic [LINE_W-1:0] line_rdata_reg;

    always_ff @(posedge aclk) begin
        if (accept && line_wr) begin
            line_mem[slot] <= LINE_W'(pair_sum);
        end
        if (accept && line_rd) begin
            line_rdata_reg <= line_mem[slot];
        end
    end

    // first stage: pair sums waiting for the line read
    logic                   v1_reg;
    logic [3:0][SUM2_W-1:0] sum1_reg;
    logic                   quad1_reg;
    logic                   last1_reg;
    logic                   flt_ready;
    filt_item_t             flt_item;

    assign s_tready = !v1_reg || flt_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (s_tready) begin
            v1_reg <= accept && emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && emit) begin
            sum1_reg  <= pair_sum;
            quad1_reg <= line_rd;
            last1_reg <= emit_last;
        end
    end

    // vertical add of the stored row
    always_comb begin
        logic [3:0][SUM2_W-1:0] line_sum;
        line_sum = line_rdata_reg;
        for (int k = 0; k < 4; k++) begin
            flt_item.sum[k] = SUM4_W'(sum1_reg[k]) +
                              (quad1_reg ? SUM4_W'(line_sum[k]) : SUM4_W'(0));
        end
        flt_item.quad = quad1_reg;
        flt_item.last = last1_reg;
    end

    pixel_t out_pixel;

    mawr_filter u_filter (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v1_reg),
        .in_ready  (flt_ready),
        .in_item   (flt_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_pixel (out_pixel),
        .out_last  (m_tlast)
    );

    assign m_tdata = 32'(out_pixel);

    // checks
    a_line_one_access: assert property (@(posedge aclk) disable iff (!aresetn)
        !(line_wr && line_rd))
        else $error("line memory read and write decoded together");

    a_emit_enters_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && emit) |=> v1_reg)
        else $error("emitting pixel did not enter the first stage");

    a_cfg_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en |=> (col_reg == '0) && (row_reg == '0))
        else $error("configuration write did not restart the frame position");

    a_pos_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (DIM_W'(col_reg) < width_reg) || $past(cfg_wr_en))
        else $error("column position beyond the source width");

endmodule
